[src/transient_slot_pool_with_aging_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the transient slot pool
// Concurrent property checks, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef TRANSIENT_SLOT_POOL_WITH_AGING_ASSERT_SVH
`define TRANSIENT_SLOT_POOL_WITH_AGING_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Property that must hold at every edge outside reset
`define TSPA_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("tspa assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent
`define TSPA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tspa assertion failed");
`else
`define TSPA_ASSERT(lbl, prop)
`define TSPA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[src/tspa_pkg.sv]
// ----------------------------------------------------------------------------
// tspa_pkg
// Types and codes shared by the transient slot pool.
// ----------------------------------------------------------------------------
`default_nettype none
package tspa_pkg;

	// request modes
	localparam logic [1:0] MODE_ACQUIRE = 2'd0;
	localparam logic [1:0] MODE_BEGIN   = 2'd1;
	localparam logic [1:0] MODE_END     = 2'd2;
	localparam logic [1:0] MODE_NONE    = 2'd3;

	// configuration register indexes
	localparam logic CFG_KEEP_FRAMES   = 1'b0;
	localparam logic CFG_RELEASE_DELAY = 1'b1;

	// releases per begin-frame item
	localparam int unsigned MAX_RELEASES = 16;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] frame_number;
		logic [63:0] descriptor_key;
		logic [15:0] first_pass;
		logic [15:0] last_pass;
	} in_t;

	typedef struct packed {
		logic [3:0]  entry_index;
		logic [15:0] resource_id;
		logic        created;
		logic        table_full;
		logic        released_valid;
		logic [4:0]  evicted_count;
		logic        pending_overflow;
		logic        last;
	} out_t;

	typedef struct packed {
		logic [63:0] key;
		logic [31:0] busy_frame;
		logic [15:0] busy_until;
		logic [31:0] last_used;
		logic [15:0] resource;
	} slot_t;

	typedef struct packed {
		logic [31:0] due;
		logic [15:0] resource;
	} pend_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ZERO,
		ST_ACQ_RD,
		ST_ACQ_CMP,
		ST_BEG_RD,
		ST_BEG_CMP,
		ST_BEG_FIN,
		ST_END_RD,
		ST_END_CMP,
		ST_END_MV
	} state_t;

endpackage
`default_nettype wire

[src/transient_slot_pool_with_aging.sv]
// ----------------------------------------------------------------------------
// transient_slot_pool_with_aging
// First-fit pool of keyed resources with aging eviction and deferred release.
// ----------------------------------------------------------------------------
// The slot table and the pending-release list each live in a single-port
// synchronous memory and are walked one entry at a time. An acquire reads
// and compares each slot in turn until a hit or the end of the table; an
// end frame compares each slot and moves the last slot into an evicted
// one's place; a begin frame compares each pending entry. Results leave
// through an output register, so a stalled consumer holds the walk only
// when a further result is ready to go. Configuration is taken while idle.
`default_nettype none
module transient_slot_pool_with_aging #(
	parameter int unsigned POOL_SLOTS    = 16,
	parameter int unsigned PENDING_DEPTH = 16
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output      logic            in_stall,
	input  wire tspa_pkg::in_t   in_data,
	output      logic            out_valid,
	input  wire logic            out_stall,
	output      tspa_pkg::out_t  out_data,
	input  wire logic            cfg_valid,
	output      logic            cfg_ready,
	input  wire logic            cfg_index,
	input  wire logic [7:0]      cfg_data
);

	localparam int SW = $clog2(POOL_SLOTS);
	localparam int PW = $clog2(PENDING_DEPTH);
	localparam logic [SW:0] SLOTS_C = (SW+1)'(POOL_SLOTS);
	localparam logic [PW:0] PEND_C  = (PW+1)'(PENDING_DEPTH);
	localparam logic [4:0]  MAXR_C  = 5'(tspa_pkg::MAX_RELEASES);

	// memories
	tspa_pkg::slot_t slot_mem [POOL_SLOTS];
	tspa_pkg::pend_t pend_mem [PENDING_DEPTH];
	tspa_pkg::slot_t slot_rd_q;
	tspa_pkg::pend_t pend_rd_q;

	logic            slot_re, slot_we, pend_re, pend_we;
	logic [SW-1:0]   slot_raddr, slot_waddr;
	logic [PW-1:0]   pend_raddr, pend_waddr;
	tspa_pkg::slot_t slot_wdata;
	tspa_pkg::pend_t pend_wdata;

	// control and working registers
	tspa_pkg::state_t state_q, state_d;
	tspa_pkg::in_t    req_q, req_d;
	tspa_pkg::out_t   out_q, out_d;
	logic             out_valid_q, out_valid_d;
	logic [SW:0]      idx_q, idx_d, slot_count_q, slot_count_d;
	logic [PW:0]      pend_count_q, pend_count_d, keep_q, keep_d;
	logic [31:0]      cur_q, cur_d, due_q, due_d;
	logic [15:0]      next_id_q, next_id_d, hold_id_q, hold_id_d;
	logic             hold_v_q, hold_v_d, ovf_q, ovf_d;
	logic [4:0]       n_q, n_d, ev_q, ev_d;
	logic [7:0]       keep_frames_q, release_delay_q;

	logic             out_free, hit, due_now, idle_old;
	logic [32:0]      due_sum;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != tspa_pkg::ST_IDLE);
	assign cfg_ready = (state_q == tspa_pkg::ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// compare terms on the registered read data
	assign hit = (slot_rd_q.key == req_q.descriptor_key) &&
		!((slot_rd_q.busy_frame == cur_q) && (slot_rd_q.busy_until >= req_q.first_pass));
	assign due_now  = (pend_rd_q.due <= cur_q) && (n_q < MAXR_C);
	assign idle_old = ({1'b0, slot_rd_q.last_used} + {25'd0, keep_frames_q}) < {1'b0, cur_q};
	assign due_sum  = {1'b0, cur_q} + {25'd0, release_delay_q};

	// next state, memory control and results
	always_comb begin
		state_d      = state_q;
		req_d        = req_q;
		out_d        = out_q;
		out_valid_d  = out_valid_q && out_stall;
		idx_d        = idx_q;
		slot_count_d = slot_count_q;
		pend_count_d = pend_count_q;
		keep_d       = keep_q;
		cur_d        = cur_q;
		due_d        = due_q;
		next_id_d    = next_id_q;
		hold_id_d    = hold_id_q;
		hold_v_d     = hold_v_q;
		ovf_d        = ovf_q;
		n_d          = n_q;
		ev_d         = ev_q;
		slot_re      = 1'b0;
		slot_we      = 1'b0;
		slot_raddr   = idx_q[SW-1:0];
		slot_waddr   = idx_q[SW-1:0];
		slot_wdata   = slot_rd_q;
		pend_re      = 1'b0;
		pend_we      = 1'b0;
		pend_raddr   = idx_q[PW-1:0];
		pend_waddr   = keep_q[PW-1:0];
		pend_wdata   = pend_rd_q;
		unique case (state_q)
			tspa_pkg::ST_IDLE: begin
				if (in_valid) begin
					req_d = in_data;
					idx_d = '0;
					case (in_data.mode)
						tspa_pkg::MODE_ACQUIRE: state_d = tspa_pkg::ST_ACQ_RD;
						tspa_pkg::MODE_BEGIN: begin
							cur_d    = in_data.frame_number;
							keep_d   = '0;
							n_d      = '0;
							hold_v_d = 1'b0;
							state_d  = tspa_pkg::ST_BEG_RD;
						end
						tspa_pkg::MODE_END: begin
							ev_d    = '0;
							ovf_d   = 1'b0;
							due_d   = due_sum[32] ? 32'hFFFF_FFFF : due_sum[31:0];
							state_d = tspa_pkg::ST_END_RD;
						end
						default: state_d = tspa_pkg::ST_ZERO;
					endcase
				end
			end
			tspa_pkg::ST_ZERO: begin
				if (out_free) begin
					out_d       = '0;
					out_d.last  = 1'b1;
					out_valid_d = 1'b1;
					state_d     = tspa_pkg::ST_IDLE;
				end
			end
			// acquire: first-fit walk, append on miss
			tspa_pkg::ST_ACQ_RD: begin
				if (idx_q >= slot_count_q) begin
					if (out_free) begin
						out_d       = '0;
						out_d.last  = 1'b1;
						out_valid_d = 1'b1;
						state_d     = tspa_pkg::ST_IDLE;
						if (slot_count_q == SLOTS_C) begin
							out_d.table_full = 1'b1;
						end else begin
							slot_we      = 1'b1;
							slot_waddr   = slot_count_q[SW-1:0];
							slot_wdata   = '{req_q.descriptor_key, cur_q, req_q.last_pass,
								cur_q, next_id_q};
							out_d.entry_index = 4'(slot_count_q[SW-1:0]);
							out_d.resource_id = next_id_q;
							out_d.created     = 1'b1;
							next_id_d    = next_id_q + 16'd1;
							slot_count_d = slot_count_q + 1'b1;
						end
					end
				end else begin
					slot_re = 1'b1;
					state_d = tspa_pkg::ST_ACQ_CMP;
				end
			end
			tspa_pkg::ST_ACQ_CMP: begin
				if (hit) begin
					if (out_free) begin
						slot_we    = 1'b1;
						slot_wdata = '{slot_rd_q.key, cur_q, req_q.last_pass, cur_q,
							slot_rd_q.resource};
						out_d             = '0;
						out_d.entry_index = 4'(idx_q[SW-1:0]);
						out_d.resource_id = slot_rd_q.resource;
						out_d.last        = 1'b1;
						out_valid_d       = 1'b1;
						state_d           = tspa_pkg::ST_IDLE;
					end
				end else begin
					idx_d   = idx_q + 1'b1;
					state_d = tspa_pkg::ST_ACQ_RD;
				end
			end
			// begin frame: release due ids, compact the rest
			tspa_pkg::ST_BEG_RD: begin
				if ({{(SW > PW ? 0 : PW-SW){1'b0}}, idx_q} >= {{(PW > SW ? 0 : SW-PW){1'b0}},
						pend_count_q}) begin
					state_d = tspa_pkg::ST_BEG_FIN;
				end else begin
					pend_re = 1'b1;
					state_d = tspa_pkg::ST_BEG_CMP;
				end
			end
			tspa_pkg::ST_BEG_CMP: begin
				if (due_now) begin
					if (!hold_v_q || out_free) begin
						if (hold_v_q) begin
							out_d                = '0;
							out_d.resource_id    = hold_id_q;
							out_d.released_valid = 1'b1;
							out_valid_d          = 1'b1;
						end
						hold_v_d  = 1'b1;
						hold_id_d = pend_rd_q.resource;
						n_d       = n_q + 5'd1;
						idx_d     = idx_q + 1'b1;
						state_d   = tspa_pkg::ST_BEG_RD;
					end
				end else begin
					pend_we = 1'b1;
					keep_d  = keep_q + 1'b1;
					idx_d   = idx_q + 1'b1;
					state_d = tspa_pkg::ST_BEG_RD;
				end
			end
			tspa_pkg::ST_BEG_FIN: begin
				if (out_free) begin
					out_d                = '0;
					out_d.resource_id    = hold_v_q ? hold_id_q : 16'd0;
					out_d.released_valid = hold_v_q;
					out_d.last           = 1'b1;
					out_valid_d          = 1'b1;
					pend_count_d         = keep_q;
					state_d              = tspa_pkg::ST_IDLE;
				end
			end
			// end frame: evict idle slots, move the last slot into the gap
			tspa_pkg::ST_END_RD: begin
				if (idx_q >= slot_count_q) begin
					if (out_free) begin
						out_d                  = '0;
						out_d.evicted_count    = ev_q;
						out_d.pending_overflow = ovf_q;
						out_d.last             = 1'b1;
						out_valid_d            = 1'b1;
						state_d                = tspa_pkg::ST_IDLE;
					end
				end else begin
					slot_re = 1'b1;
					state_d = tspa_pkg::ST_END_CMP;
				end
			end
			tspa_pkg::ST_END_CMP: begin
				if (idle_old) begin
					if (pend_count_q < PEND_C) begin
						pend_we      = 1'b1;
						pend_waddr   = pend_count_q[PW-1:0];
						pend_wdata   = '{due_q, slot_rd_q.resource};
						pend_count_d = pend_count_q + 1'b1;
					end else begin
						ovf_d = 1'b1;
					end
					if (ev_q != 5'd31) ev_d = ev_q + 5'd1;
					slot_re      = 1'b1;
					slot_raddr   = SW'(slot_count_q - 1'b1);
					slot_count_d = slot_count_q - 1'b1;
					state_d      = tspa_pkg::ST_END_MV;
				end else begin
					idx_d   = idx_q + 1'b1;
					state_d = tspa_pkg::ST_END_RD;
				end
			end
			tspa_pkg::ST_END_MV: begin
				slot_we = 1'b1;
				state_d = tspa_pkg::ST_END_RD;
			end
			default: state_d = tspa_pkg::ST_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tspa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q     <= 1'b0;
			slot_count_q    <= '0;
			pend_count_q    <= '0;
			cur_q           <= '0;
			next_id_q       <= '0;
			hold_v_q        <= 1'b0;
			keep_frames_q   <= 8'd2;
			release_delay_q <= 8'd2;
		end else begin
			out_valid_q  <= out_valid_d;
			slot_count_q <= slot_count_d;
			pend_count_q <= pend_count_d;
			cur_q        <= cur_d;
			next_id_q    <= next_id_d;
			hold_v_q     <= hold_v_d;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == tspa_pkg::CFG_KEEP_FRAMES) keep_frames_q <= cfg_data;
				else release_delay_q <= cfg_data;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		req_q     <= req_d;
		out_q     <= out_d;
		idx_q     <= idx_d;
		keep_q    <= keep_d;
		due_q     <= due_d;
		hold_id_q <= hold_id_d;
		ovf_q     <= ovf_d;
		n_q       <= n_d;
		ev_q      <= ev_d;
	end

	// slot memory
	always_ff @(posedge clk) begin
		if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
		if (slot_re) slot_rd_q <= slot_mem[slot_raddr];
	end

	// pending memory
	always_ff @(posedge clk) begin
		if (pend_we) pend_mem[pend_waddr] <= pend_wdata;
		if (pend_re) pend_rd_q <= pend_mem[pend_raddr];
	end

	`include "transient_slot_pool_with_aging_assert.svh"

	`TSPA_ASSERT(a_slot_bound, slot_count_q <= SLOTS_C)
	`TSPA_ASSERT(a_pend_bound, pend_count_q <= PEND_C)
	`TSPA_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, in_stall)
	`TSPA_ASSERT(a_no_double_access, !(slot_re && slot_we) && !(pend_re && pend_we))

endmodule
`default_nettype wire
